@@ sv/ple_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg: shared types for the positional list engine
// Command and status codes, cell control and result record.
// ----------------------------------------------------------------------------
package ple_pkg;

	// count field width (holds 0..127)
	localparam int CNT_W = 7;
	localparam int VAL_W = 32;
	localparam int POS_W = 8;

	typedef enum logic [2:0] {
		CMD_INS_HEAD = 3'd0,
		CMD_INS_TAIL = 3'd1,
		CMD_INS_AT   = 3'd2,
		CMD_DEL_HEAD = 3'd3,
		CMD_DEL_TAIL = 3'd4,
		CMD_DEL_AT   = 3'd5,
		CMD_DUMP     = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// what every cell of the row does this cycle
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2,
		CELL_ROT  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [CNT_W-1:0]   idx;
		logic [CNT_W-1:0]   cnt;
	} cell_ctl_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_DUMP = 1'b1
	} fsm_state_t;

	typedef struct packed {
		status_t                  status;
		logic signed [VAL_W-1:0]  element;
		logic [CNT_W-1:0]         count;
		logic                     last;
	} res_t;

endpackage

@@ sv/ple_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_if: valid/ready channels of the positional list engine
// Command channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface ple_cmd_if;
	logic                valid;
	logic                ready;
	logic [2:0]          command;
	logic signed [31:0]  value;
	logic [7:0]          position;

	modport source (output valid, command, value, position, input ready);
	modport sink   (input valid, command, value, position, output ready);
endinterface

interface ple_res_if;
	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic signed [31:0]  element;
	logic [6:0]          count;
	logic                last;

	modport source (output valid, status, element, count, last, input ready);
	modport sink   (input valid, status, element, count, last, output ready);
endinterface

@@ sv/ple_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_cell: one storage cell of the list row
// Holds one element; takes its left or right neighbor, the new value or
// the head value, as the broadcast control and its own index decide.
// ----------------------------------------------------------------------------
module ple_cell (
	input  logic                             clk,
	input  ple_pkg::cell_ctl_t               ctl,
	input  logic [ple_pkg::CNT_W-1:0]        index,
	input  logic signed [ple_pkg::VAL_W-1:0] left_val,
	input  logic signed [ple_pkg::VAL_W-1:0] right_val,
	input  logic signed [ple_pkg::VAL_W-1:0] head_val,
	input  logic signed [ple_pkg::VAL_W-1:0] new_val,
	output logic signed [ple_pkg::VAL_W-1:0] val
);
	import ple_pkg::*;

	logic signed [VAL_W-1:0] val_q;
	logic signed [VAL_W-1:0] val_nx;
	logic [CNT_W-1:0]        index_p1;

	assign index_p1 = index + CNT_W'(1);

	// neighbor select
	always_comb begin
		val_nx = val_q;
		case (ctl.op)
			CELL_INS: begin
				if (index > ctl.idx) begin
					val_nx = left_val;
				end else if (index == ctl.idx) begin
					val_nx = new_val;
				end
			end
			CELL_DEL: begin
				if (index >= ctl.idx) begin
					val_nx = right_val;
				end
			end
			CELL_ROT: begin
				// last occupied cell wraps the head around
				if (index_p1 < ctl.cnt) begin
					val_nx = right_val;
				end else if (index_p1 == ctl.cnt) begin
					val_nx = head_val;
				end
			end
			default: begin
				val_nx = val_q;
			end
		endcase
	end

	// payload register, no reset
	always_ff @(posedge clk) begin
		val_q <= val_nx;
	end

	assign val = val_q;

endmodule

@@ sv/positional_list_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_unit: ordered list of signed words in a cell row
// Inserts, deletes and dumps by head, tail or one-based position.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_ch carries command, value and position; a transfer happens when
//   valid and ready are both high. res_ch carries status, element, count
//   and last. Every command except a dump returns one result; a dump of a
//   non-empty list returns one result per element, head first, with last
//   set on the final one.
// Timing:
//   Insert and delete shift all cells toward or away from the position in
//   parallel, and the result is written into the queue in the same cycle
//   as the transfer. A dump first enters the dump state, then for each
//   element emits the head and rotates the row left past cell 0. The row
//   rotation sets the dump rate; no command is taken during a dump.
// Stall and reset:
//   A two-entry result queue lets a command transfer while a result waits;
//   cmd_ch.ready drops only when the queue is full or a dump runs, and a
//   stalled dump simply pauses. Reset empties the list and the queue at
//   once; cell contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
	parameter int DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	ple_cmd_if.sink      cmd_ch,
	ple_res_if.source    res_ch
);
	import ple_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	// control state
	fsm_state_t        state_q, state_nx;
	logic [CNT_W-1:0]  cnt_q, cnt_nx;
	logic [CNT_W-1:0]  dump_q, dump_nx;
	logic [1:0]        occ_q;
	res_t              slot0_q, slot1_q;

	// row wiring
	cell_ctl_t                 ctl;
	logic signed [VAL_W-1:0]   cell_val [DEPTH];

	logic              accept;
	logic              room;
	logic              pop;
	logic              push;
	res_t              wres;
	logic [POS_W:0]    pos_ext;
	logic [POS_W:0]    cnt_ext;
	logic [CNT_W-1:0]  pos_idx;
	logic              full;
	logic              dump_last;

	assign room    = (occ_q != 2'd2);
	assign pop     = res_ch.valid && res_ch.ready;
	assign accept  = cmd_ch.valid && cmd_ch.ready;
	assign pos_ext = {1'b0, cmd_ch.position};
	assign cnt_ext = {{(POS_W + 1 - CNT_W){1'b0}}, cnt_q};
	assign pos_idx = CNT_W'(cmd_ch.position - POS_W'(1));
	assign full    = (cnt_q == DEPTH_C);
	assign dump_last = (dump_q == (cnt_q - CNT_W'(1)));

	assign cmd_ch.ready = (state_q == S_IDLE) && room;

	// command decode and dump sequencing
	always_comb begin
		state_nx    = state_q;
		cnt_nx      = cnt_q;
		dump_nx     = dump_q;
		ctl.op      = CELL_HOLD;
		ctl.idx     = '0;
		ctl.cnt     = cnt_q;
		push        = 1'b0;
		wres.status = ST_OK;
		wres.element = '0;
		wres.last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					push = 1'b1;
					case (cmd_t'(cmd_ch.command))
						CMD_INS_HEAD: begin
							if (full) begin
								wres.status = ST_FULL;
							end else begin
								ctl.op = CELL_INS;
								ctl.idx = '0;
								cnt_nx = cnt_q + CNT_W'(1);
							end
						end
						CMD_INS_TAIL: begin
							if (full) begin
								wres.status = ST_FULL;
							end else begin
								ctl.op = CELL_INS;
								ctl.idx = cnt_q;
								cnt_nx = cnt_q + CNT_W'(1);
							end
						end
						CMD_INS_AT: begin
							if (cmd_ch.position == '0 || pos_ext > cnt_ext + (POS_W + 1)'(1)) begin
								wres.status = ST_BADPOS;
							end else if (full) begin
								wres.status = ST_FULL;
							end else begin
								ctl.op = CELL_INS;
								ctl.idx = pos_idx;
								cnt_nx = cnt_q + CNT_W'(1);
							end
						end
						CMD_DEL_HEAD: begin
							if (cnt_q == '0) begin
								wres.status = ST_EMPTY;
							end else begin
								ctl.op = CELL_DEL;
								ctl.idx = '0;
								cnt_nx = cnt_q - CNT_W'(1);
							end
						end
						CMD_DEL_TAIL: begin
							if (cnt_q == '0) begin
								wres.status = ST_EMPTY;
							end else begin
								cnt_nx = cnt_q - CNT_W'(1);
							end
						end
						CMD_DEL_AT: begin
							if (cmd_ch.position == '0 || pos_ext > cnt_ext) begin
								wres.status = ST_BADPOS;
							end else begin
								ctl.op = CELL_DEL;
								ctl.idx = pos_idx;
								cnt_nx = cnt_q - CNT_W'(1);
							end
						end
						CMD_DUMP: begin
							if (cnt_q == '0) begin
								wres.status = ST_EMPTY;
							end else begin
								push = 1'b0;
								state_nx = S_DUMP;
								dump_nx = '0;
							end
						end
						default: begin
							wres.status = ST_OK;
						end
					endcase
				end
			end
			S_DUMP: begin
				// emit head, rotate row left by one
				if (room) begin
					push = 1'b1;
					wres.element = cell_val[0];
					wres.last = dump_last;
					ctl.op = CELL_ROT;
					dump_nx = dump_q + CNT_W'(1);
					if (dump_last) begin
						state_nx = S_IDLE;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
		wres.count = cnt_nx;
	end

	// cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VAL_W-1:0] left_w;
		logic signed [VAL_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = cmd_ch.value;
		end else begin : g_mid_l
			assign left_w = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign right_w = cell_val[i];
		end else begin : g_mid_r
			assign right_w = cell_val[i+1];
		end
		ple_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.index     (CNT_W'(i)),
			.left_val  (left_w),
			.right_val (right_w),
			.head_val  (cell_val[0]),
			.new_val   (cmd_ch.value),
			.val       (cell_val[i])
		);
	end

	// state, count, dump index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			dump_q  <= '0;
		end else begin
			state_q <= state_nx;
			cnt_q   <= cnt_nx;
			dump_q  <= dump_nx;
		end
	end

	// result queue occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10: occ_q <= occ_q + 2'd1;
				2'b01: occ_q <= occ_q - 2'd1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	// result queue payload
	always_ff @(posedge clk) begin
		if (occ_q == 2'd0) begin
			if (push) begin
				slot0_q <= wres;
			end
		end else if (occ_q == 2'd1) begin
			if (push && pop) begin
				slot0_q <= wres;
			end else if (push) begin
				slot1_q <= wres;
			end
		end else begin
			if (pop) begin
				slot0_q <= slot1_q;
			end
		end
	end

	assign res_ch.valid   = (occ_q != 2'd0);
	assign res_ch.status  = slot0_q.status;
	assign res_ch.element = slot0_q.element;
	assign res_ch.count   = slot0_q.count;
	assign res_ch.last    = slot0_q.last;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("list count above depth");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q != 2'd3)
		else $error("result queue overflow");

	a_dump_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> !cmd_ch.ready)
		else $error("command taken during dump");

	a_dump_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |=> $stable(cnt_q))
		else $error("count changed during dump");

	a_dump_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP && push && wres.last) |=> (state_q == S_IDLE))
		else $error("dump did not end after last element");

endmodule
